/* hw/rtl/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// Shared constants, types and helpers for the prime sieve counter.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int MAX_LIMIT   = 1048576;
    localparam int WORD_BITS   = 64;
    localparam int STORE_WORDS = (MAX_LIMIT + WORD_BITS - 1) / WORD_BITS;

    localparam int LIMIT_W = 32;
    localparam int COUNT_W = 21;
    localparam int ADDR_W  = $clog2(STORE_WORDS);
    localparam int WCNT_W  = ADDR_W + 1;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int POP_W   = $clog2(WORD_BITS + 1);
    localparam int LIM_W   = $clog2(MAX_LIMIT + 1);
    localparam int N_W     = LIM_W + 1;
    localparam int P_W     = (LIM_W + 1) / 2 + 1;

    // odd positions set; word 0 additionally has 2 set and 0,1 clear
    localparam logic [WORD_BITS-1:0] INIT_WORD  = {(WORD_BITS / 2){2'b10}};
    localparam logic [WORD_BITS-1:0] FIRST_WORD = INIT_WORD ^ WORD_BITS'(6);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PCHK,
        ST_PTST,
        ST_MRD,
        ST_MLD,
        ST_MCLR,
        ST_CRD,
        ST_CPOP,
        ST_CACC,
        ST_DONE
    } state_t;

    function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] x);
        logic [POP_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < WORD_BITS; k++)
        begin
            acc = acc + POP_W'(x[k]);
        end
        return acc;
    endfunction

endpackage

/* hw/rtl/psc_ram.sv */
// ----------------------------------------------------------------------------
// psc_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module psc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/prime_sieve_counter_unit.sv */
// ----------------------------------------------------------------------------
// prime_sieve_counter_unit
// Counts the primes strictly below a limit with a sieve in a bit store.
// ----------------------------------------------------------------------------
// Usage:
//   Send a 32-bit limit on the s_axis channel; one result comes back on
//   m_axis: the prime count in tdata, the out-of-range flag in tuser.
//   Limits above the built maximum return count 0 with the flag set;
//   limits of 0, 1 or 2 return count 0.
//   For an in-range limit the sequencer runs three passes over one
//   64-bit-wide sieve RAM: a fill pass (one word per cycle), a marking
//   pass (per odd candidate a read to test it; per word touched by its
//   multiples one read, then its bits cleared one by one, write overlapped
//   with the next read), and a count pass (read, popcount, add per word).
//   s_axis_tready is high only while the sequencer is idle; one item is
//   worked on at a time. The result sits in an output register, so the
//   next limit is taken while it waits; a stalled receiver holds a finished
//   count until the output register frees.
//   Reset returns the sequencer to idle and drops m_axis_tvalid; the sieve
//   RAM needs no clearing since every pass writes before it reads.
// ----------------------------------------------------------------------------
module prime_sieve_counter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] limit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] prime_count, [23:21] zero
    output logic        m_axis_tuser    // [0] out_of_range
);
    import psc_pkg::*;

    state_t              state_reg, state_next;
    logic [LIM_W-1:0]    lim_reg, lim_next;
    logic [WCNT_W-1:0]   words_reg, words_next;
    logic [WCNT_W-1:0]   idx_reg, idx_next;
    logic [P_W-1:0]      p_reg, p_next;
    logic [N_W-1:0]      psq_reg, psq_next;
    logic [N_W-1:0]      n_reg, n_next;
    logic [N_W-1:0]      step_reg, step_next;
    logic [ADDR_W-1:0]   cur_reg, cur_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [POP_W-1:0]    pop_reg, pop_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                oor_reg, oor_next;
    logic                out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                out_oor_reg, out_oor_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                in_xfer;
    logic [ADDR_W-1:0]   n_word;
    logic                n_in;
    logic [WORD_BITS-1:0] n_bit;
    logic [WORD_BITS-1:0] tail_mask;
    logic [LIM_W-1:0]    lim_round;

    psc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(24 - COUNT_W){1'b0}}, out_count_reg};
    assign m_axis_tuser  = out_oor_reg;

    assign n_word    = n_reg[BIT_W +: ADDR_W];
    assign n_in      = (n_reg < N_W'(lim_reg));
    assign n_bit     = WORD_BITS'(1) << n_reg[BIT_W-1:0];
    assign lim_round = lim_reg + LIM_W'(WORD_BITS - 1);

    always_comb
    begin
        tail_mask = '1;
        if ((idx_reg == words_reg - WCNT_W'(1)) && (lim_reg[BIT_W-1:0] != '0))
        begin
            tail_mask = ~({WORD_BITS{1'b1}} << lim_reg[BIT_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg       <= lim_next;
        words_reg     <= words_next;
        idx_reg       <= idx_next;
        p_reg         <= p_next;
        psq_reg       <= psq_next;
        n_reg         <= n_next;
        step_reg      <= step_next;
        cur_reg       <= cur_next;
        word_reg      <= word_next;
        pop_reg       <= pop_next;
        count_reg     <= count_next;
        oor_reg       <= oor_next;
        out_count_reg <= out_count_next;
        out_oor_reg   <= out_oor_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        lim_next       = lim_reg;
        words_next     = words_reg;
        idx_next       = idx_reg;
        p_next         = p_reg;
        psq_next       = psq_reg;
        n_next         = n_reg;
        step_next      = step_reg;
        cur_next       = cur_reg;
        word_next      = word_reg;
        pop_next       = pop_reg;
        count_next     = count_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_count_next = out_count_reg;
        out_oor_next   = out_oor_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[ADDR_W-1:0];
        ram_wdata      = (idx_reg == '0) ? FIRST_WORD : INIT_WORD;
        ram_raddr      = n_word;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    lim_next   = s_axis_tdata[LIM_W-1:0];
                    count_next = '0;
                    idx_next   = '0;
                    oor_next   = (s_axis_tdata > LIMIT_W'(MAX_LIMIT));
                    if ((s_axis_tdata > LIMIT_W'(MAX_LIMIT)) || (s_axis_tdata <= 32'd2))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                words_next = lim_round[LIM_W-1:BIT_W];
                if (idx_reg == lim_round[LIM_W-1:BIT_W])
                begin
                    p_next     = P_W'(3);
                    psq_next   = N_W'(9);
                    state_next = ST_PCHK;
                end
                else
                begin
                    ram_we   = 1'b1;
                    idx_next = idx_reg + WCNT_W'(1);
                end
            end
            ST_PCHK:
            begin
                ram_raddr = ADDR_W'(p_reg[P_W-1:BIT_W]);
                if (psq_reg >= N_W'(lim_reg))
                begin
                    idx_next   = '0;
                    state_next = ST_CRD;
                end
                else
                begin
                    state_next = ST_PTST;
                end
            end
            ST_PTST:
            begin
                if (ram_rdata[p_reg[BIT_W-1:0]])
                begin
                    n_next     = psq_reg;
                    step_next  = N_W'({p_reg, 1'b0});
                    state_next = ST_MRD;
                end
                else
                begin
                    p_next     = p_reg + P_W'(2);
                    psq_next   = psq_reg + N_W'({p_reg + P_W'(1), 2'b00});
                    state_next = ST_PCHK;
                end
            end
            ST_MRD:
            begin
                cur_next   = n_word;
                state_next = ST_MLD;
            end
            ST_MLD:
            begin
                word_next  = ram_rdata & ~n_bit;
                n_next     = n_reg + step_reg;
                state_next = ST_MCLR;
            end
            ST_MCLR:
            begin
                if (n_in && (n_word == cur_reg))
                begin
                    word_next = word_reg & ~n_bit;
                    n_next    = n_reg + step_reg;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg;
                    ram_wdata = word_reg;
                    if (n_in)
                    begin
                        cur_next   = n_word;
                        state_next = ST_MLD;
                    end
                    else
                    begin
                        p_next     = p_reg + P_W'(2);
                        psq_next   = psq_reg + N_W'({p_reg + P_W'(1), 2'b00});
                        state_next = ST_PCHK;
                    end
                end
            end
            ST_CRD:
            begin
                ram_raddr  = idx_reg[ADDR_W-1:0];
                state_next = ST_CPOP;
            end
            ST_CPOP:
            begin
                pop_next   = popcount(ram_rdata & tail_mask);
                state_next = ST_CACC;
            end
            ST_CACC:
            begin
                count_next = count_reg + COUNT_W'(pop_reg);
                idx_next   = idx_reg + WCNT_W'(1);
                if (idx_reg + WCNT_W'(1) == words_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CRD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = oor_reg ? '0 : count_reg;
                    out_oor_next   = oor_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[COUNT_W-1:0] == '0))
        else $error("out-of-range result with nonzero count");

    a_rmw_ports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MCLR && ram_we && n_in) |-> (ram_waddr != ram_raddr))
        else $error("overlapped write and read hit the same word");

    a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MLD) |-> (n_reg < N_W'(lim_reg)))
        else $error("marking past the limit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !oor_reg) |-> (count_reg <= lim_reg))
        else $error("count exceeds limit");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after input transfer");

endmodule

/* test/prime_sieve_counter_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_sieve_counter_unit_tb
// Streams limits into the sieve counter and checks every returned count and
// range flag against a prime table built once at time zero. A directed pass
// covers the boundaries, the square-of-prime edges, store reuse after large
// limits, the maximum and out-of-range values; a random pass follows, mostly
// small limits, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module prime_sieve_counter_unit_tb;

    import psc_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               oor;
    } count_result_t;

    class prime_count_board;
        bit                 composite [MAX_LIMIT];
        logic [COUNT_W-1:0] primes_below [MAX_LIMIT + 1];
        count_result_t      expected_counts [$];
        int unsigned        errors;
        int unsigned        checked;

        function new();
            int unsigned run;
            errors  = 0;
            checked = 0;
            for (int unsigned p = 2; p * p < MAX_LIMIT; p++)
            begin
                if (!composite[p])
                begin
                    for (int unsigned n = p * p; n < MAX_LIMIT; n += p)
                        composite[n] = 1'b1;
                end
            end
            run = 0;
            for (int unsigned n = 0; n <= MAX_LIMIT; n++)
            begin
                primes_below[n] = COUNT_W'(run);
                if (n >= 2 && n < MAX_LIMIT && !composite[n])
                    run++;
            end
        endfunction

        function count_result_t predict_count(logic [LIMIT_W-1:0] lim);
            count_result_t r;
            if (lim > MAX_LIMIT)
            begin
                r.count = '0;
                r.oor   = 1'b1;
            end
            else
            begin
                r.oor   = 1'b0;
                r.count = (lim <= 2) ? '0 : primes_below[lim];
            end
            return r;
        endfunction

        function void note_limit(logic [LIMIT_W-1:0] lim);
            expected_counts.push_back(predict_count(lim));
        endfunction

        function void check_result(logic [23:0] tdata, logic tuser);
            count_result_t exp_r;
            if (expected_counts.size() == 0)
            begin
                $error("unexpected result: prime_count=%0d out_of_range=%0d",
                       tdata[COUNT_W-1:0], tuser);
                errors++;
                return;
            end
            exp_r = expected_counts.pop_front();
            checked++;
            if (tdata[COUNT_W-1:0] !== exp_r.count)
            begin
                $error("prime_count: expected %0d, actual %0d",
                       exp_r.count, tdata[COUNT_W-1:0]);
                errors++;
            end
            if (tdata[23:COUNT_W] !== '0)
            begin
                $error("tdata padding: expected 0, actual %0d", tdata[23:COUNT_W]);
                errors++;
            end
            if (tuser !== exp_r.oor)
            begin
                $error("out_of_range: expected %0d, actual %0d", exp_r.oor, tuser);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_counts.size();
        endfunction
    endclass

    localparam logic [LIMIT_W-1:0] DIRECTED [25] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd10, 32'd25, 32'd26,
        32'd50, 32'd63, 32'd64, 32'd65, 32'd127, 32'd128, 32'd129, 32'd1000,
        32'd65536, 32'd70, 32'd1048576, 32'd200, 32'd1048577, 32'hFFFF_FFFF,
        32'h8000_0000
    };
    localparam int RANDOM_ITEMS = 76;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               s_valid = 1'b0;
    logic [LIMIT_W-1:0] s_data  = '0;
    logic               m_ready = 1'b0;
    logic               s_axis_tready;
    logic               m_axis_tvalid;
    logic [23:0]        m_axis_tdata;
    logic               m_axis_tuser;

    prime_count_board board;
    bit               pace_on = 1'b1;
    int unsigned      n_sent = 0;
    int unsigned      n_oor = 0;
    int unsigned      n_tiny = 0;
    logic [LIMIT_W-1:0] top_in_range = '0;

    prime_sieve_counter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!pace_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 200);
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return $urandom_range(0, 2);
        else if (r < 8)
            return $urandom_range(MAX_LIMIT + 1, 32'hFFFF_FFFF);
        else if (r < 10)
            return $urandom | 32'h0010_0001;
        else if (r < 85)
            return $urandom_range(3, 300);
        else if (r < 95)
            return $urandom_range(301, 3000);
        else
            return $urandom_range(3001, 20000);
    endfunction

    // starts and ends on a falling edge; valid stays high across back-to-back transfers
    task automatic send_limit(input logic [LIMIT_W-1:0] lim);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= lim;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_limit(lim);
        n_sent++;
        if (lim > MAX_LIMIT)
            n_oor++;
        else if (lim <= 2)
            n_tiny++;
        else if (lim > top_in_range)
            top_in_range = lim;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_ready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    initial
    begin
        int unsigned run;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 40);
            m_ready <= 1'b1;
            repeat (run) @(negedge clk);
            run = pick_gap();
            if (run > 0)
            begin
                m_ready <= 1'b0;
                repeat (run) @(negedge clk);
            end
        end
    end

    initial
    begin
        board = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
            send_limit(DIRECTED[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 19 == 0)
                pace_on = ($urandom_range(0, 3) != 0);
            send_limit(pick_limit());
        end
        s_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("sent %0d limits: %0d out of range, %0d below 3, largest in-range %0d",
                 n_sent, n_oor, n_tiny, top_in_range);
        $display("checked %0d results, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0)
            $display("** prime_sieve_counter_unit: PASSED **");
        else
            $display("** prime_sieve_counter_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("timeout waiting for transfers");
        $display("** prime_sieve_counter_unit: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/psc_pkg.sv
hw/rtl/psc_ram.sv
hw/rtl/prime_sieve_counter_unit.sv
test/prime_sieve_counter_unit_tb.sv
